>>> sv/cht_pkg.sv
// ----------------------------------------------------------------------------
// cht_pkg
// Shared constants for the counting hash table: field widths, operation
// codes and the digit size of the remainder unit.
// ----------------------------------------------------------------------------
package cht_pkg;

   // Field widths
   localparam int KEY_W   = 32;
   localparam int COUNT_W = 16;
   localparam int CFG_W   = 7;

   // Saturation value of an occurrence count
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // Operation codes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   // Remainder unit: dividend bits retired per cycle and digit steps per word
   localparam int DIV_STEP   = 4;
   localparam int DIV_CYCLES = KEY_W / DIV_STEP;
   localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

   // Partial remainder carries one extra bit after the shift-in
   localparam int REM_W = CFG_W + 1;

endpackage

>>> sv/counting_hash_table.sv
// ----------------------------------------------------------------------------
// counting_hash_table
// Occurrence counter over signed 32-bit keys held in SLOTS buckets of WAYS
// ways. Insert bumps a key's count (saturating) or claims the lowest free
// way; search returns the count, or zero when the key is absent.
// ----------------------------------------------------------------------------
//
//  channel   ports                                   handshake
//  -------   -------------------------------------   -------------------------
//  request   req_operation, req_key_value            start & !busy
//  response  rsp_count, rsp_found, rsp_bucket_full   rsp_valid, one cycle
//  csr       csr_slot_count                          csr_valid & csr_ready
//
//  Once a word is taken, busy stays high while the remainder unit runs, the
//  bucket is taken from its remainder, the valid row is read, the ways are
//  probed one by one through the single read port of the key/count store,
//  and the result is committed. A probe stops at the first matching way.
//  The response shows the cycle after commit, while busy is already low, so
//  words sent back to back are taken one at a time, the next as a response shows.
//  After reset a clearing pass zeroes the valid store, one bucket a cycle,
//  through every bucket; busy stays high meanwhile. csr writes are always taken.
//  The receiver cannot stall: each response is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module counting_hash_table #(
   parameter int SLOTS = 64,
   parameter int WAYS  = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   // request
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_operation,
   input  logic signed [cht_pkg::KEY_W-1:0]    req_key_value,
   // response
   output logic                                rsp_valid,
   output logic [cht_pkg::COUNT_W-1:0]         rsp_count,
   output logic                                rsp_found,
   output logic                                rsp_bucket_full,
   // csr
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cht_pkg::CFG_W-1:0]           csr_slot_count
);

   localparam int ENTRIES = SLOTS * WAYS;
   localparam int BW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_ROW,
      ST_CHECK,
      ST_COMMIT
   } state_type;

   state_type                       state_ff;
   logic [cht_pkg::CFG_W-1:0]       slot_count_ff;
   logic [BW-1:0]                   clr_ff;
   logic                            op_ff;
   logic [cht_pkg::KEY_W-1:0]       key_ff;
   logic [BW-1:0]                   bucket_ff;
   logic [WW-1:0]                   way_ff;
   logic [AW-1:0]                   cur_ff;
   logic                            hit_ff;
   logic [AW-1:0]                   hit_addr_ff;
   logic [cht_pkg::COUNT_W-1:0]     hit_cnt_ff;
   logic                            free_ff;
   logic [AW-1:0]                   free_addr_ff;
   logic [WW-1:0]                   free_way_ff;
   logic                            rsp_valid_ff;
   logic [cht_pkg::COUNT_W-1:0]     rsp_count_ff;
   logic                            rsp_found_ff;
   logic                            rsp_full_ff;

   // Stores
   logic [cht_pkg::KEY_W-1:0]       key_mem   [ENTRIES];
   logic [cht_pkg::COUNT_W-1:0]     count_mem [ENTRIES];
   logic [WAYS-1:0]                 valid_mem [SLOTS];
   logic [cht_pkg::KEY_W-1:0]       key_rd_ff;
   logic [cht_pkg::COUNT_W-1:0]     cnt_rd_ff;
   logic [WAYS-1:0]                 vrow_ff;

   // Datapath nets
   logic [cht_pkg::KEY_W-1:0]       key_mag;
   logic [cht_pkg::CFG_W-1:0]       divisor;
   logic                            div_start;
   logic                            div_done;
   logic [cht_pkg::CFG_W-1:0]       div_rem;
   logic [AW-1:0]                   base_addr;
   logic                            mem_rd_en;
   logic [AW-1:0]                   rd_addr;
   logic                            last_way;
   logic                            way_hit;
   logic                            is_insert;
   logic                            cnt_sat;
   logic                            key_we;
   logic                            cnt_we;
   logic [AW-1:0]                   cnt_wr_addr;
   logic [cht_pkg::COUNT_W-1:0]     cnt_wr_data;
   logic                            vrow_we;
   logic [BW-1:0]                   vrow_wr_addr;
   logic [WAYS-1:0]                 vrow_wr_data;
   logic [WAYS-1:0]                 free_mask;
   logic                            accept;

   assign accept = start && (state_ff == ST_IDLE);

   // Magnitude of the key; the most negative key maps to 2^31
   assign key_mag = req_key_value[cht_pkg::KEY_W-1] ?
                    (cht_pkg::KEY_W'(0) - cht_pkg::KEY_W'(req_key_value)) :
                    cht_pkg::KEY_W'(req_key_value);

   // Clamp the bucket count into 1..SLOTS
   always_comb begin
      if (slot_count_ff == '0) begin
         divisor = cht_pkg::CFG_W'(1);
      end else if (int'(slot_count_ff) > SLOTS) begin
         divisor = cht_pkg::CFG_W'(SLOTS);
      end else begin
         divisor = slot_count_ff;
      end
   end

   assign div_start = accept;

   cht_mod_unit u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (key_mag),
      .divisor   (divisor),
      .done      (div_done),
      .remainder (div_rem)
   );

   // Probe addressing: first way at the row read, then one way a cycle
   assign base_addr = AW'(int'(bucket_ff) * WAYS);
   assign last_way  = (way_ff == WW'(WAYS - 1));
   assign mem_rd_en = (state_ff == ST_ROW) || ((state_ff == ST_CHECK) && !last_way);
   assign rd_addr   = (state_ff == ST_ROW) ? base_addr : (cur_ff + AW'(1));
   assign way_hit   = vrow_ff[way_ff] && (key_rd_ff == key_ff);

   // Commit decode
   assign is_insert    = (op_ff == cht_pkg::OP_INSERT);
   assign cnt_sat      = (hit_cnt_ff == cht_pkg::COUNT_MAX);
   assign key_we       = (state_ff == ST_COMMIT) && is_insert && !hit_ff && free_ff;
   assign cnt_we       = key_we ||
                         ((state_ff == ST_COMMIT) && is_insert && hit_ff && !cnt_sat);
   assign cnt_wr_addr  = hit_ff ? hit_addr_ff : free_addr_ff;
   assign cnt_wr_data  = hit_ff ? (hit_cnt_ff + cht_pkg::COUNT_W'(1)) :
                                  cht_pkg::COUNT_W'(1);
   assign free_mask    = WAYS'(1) << free_way_ff;
   assign vrow_we      = (state_ff == ST_CLEAR) || key_we;
   assign vrow_wr_addr = (state_ff == ST_CLEAR) ? clr_ff : bucket_ff;
   assign vrow_wr_data = (state_ff == ST_CLEAR) ? '0 : (vrow_ff | free_mask);

   // Key and count store: one write, one registered read
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[free_addr_ff] <= key_ff;
      end
      if (cnt_we) begin
         count_mem[cnt_wr_addr] <= cnt_wr_data;
      end
      if (mem_rd_en) begin
         key_rd_ff <= key_mem[rd_addr];
         cnt_rd_ff <= count_mem[rd_addr];
      end
   end

   // Valid store: one row of way bits per bucket
   always_ff @(posedge clock) begin
      if (vrow_we) begin
         valid_mem[vrow_wr_addr] <= vrow_wr_data;
      end
      if (state_ff == ST_ROW) begin
         vrow_ff <= valid_mem[bucket_ff];
      end
   end

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff <= cht_pkg::CFG_W'(64);
      end else if (csr_valid && csr_ready) begin
         slot_count_ff <= csr_slot_count;
      end
   end

   assign csr_ready = 1'b1;

   // Sequencer: clear, divide, probe ways, commit
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + BW'(1);
               if (clr_ff == BW'(SLOTS - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (start) begin
                  op_ff    <= req_operation;
                  key_ff   <= cht_pkg::KEY_W'(req_key_value);
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  bucket_ff <= BW'(div_rem);
                  state_ff  <= ST_ROW;
               end
            end
            ST_ROW: begin
               cur_ff   <= base_addr;
               way_ff   <= '0;
               hit_ff   <= 1'b0;
               free_ff  <= 1'b0;
               state_ff <= ST_CHECK;
            end
            ST_CHECK: begin
               if (way_hit) begin
                  hit_ff      <= 1'b1;
                  hit_addr_ff <= cur_ff;
                  hit_cnt_ff  <= cnt_rd_ff;
                  state_ff    <= ST_COMMIT;
               end else begin
                  if (!vrow_ff[way_ff] && !free_ff) begin
                     free_ff      <= 1'b1;
                     free_addr_ff <= cur_ff;
                     free_way_ff  <= way_ff;
                  end
                  if (last_way) begin
                     state_ff <= ST_COMMIT;
                  end else begin
                     cur_ff <= cur_ff + AW'(1);
                     way_ff <= way_ff + WW'(1);
                  end
               end
            end
            ST_COMMIT: begin
               rsp_valid_ff <= 1'b1;
               rsp_found_ff <= hit_ff;
               rsp_full_ff  <= is_insert && !hit_ff && !free_ff;
               if (hit_ff) begin
                  rsp_count_ff <= (is_insert && !cnt_sat) ? cnt_wr_data : hit_cnt_ff;
               end else if (is_insert && free_ff) begin
                  rsp_count_ff <= cht_pkg::COUNT_W'(1);
               end else begin
                  rsp_count_ff <= '0;
               end
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_count       = rsp_count_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_bucket_full = rsp_full_ff;

   // Checks
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held longer than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("block not busy after taking a request word");

   a_found_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_found && rsp_bucket_full))
      else $error("response both found and dropped");

   a_search_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (op_ff == cht_pkg::OP_SEARCH)) |-> !rsp_bucket_full)
      else $error("search reported a full bucket");

endmodule

>>> sv/cht_mod_unit.sv
// ----------------------------------------------------------------------------
// cht_mod_unit
// Iterative restoring remainder unit: 32-bit unsigned dividend modulo a
// 7-bit nonzero divisor, four dividend bits per cycle until the word is retired.
// ----------------------------------------------------------------------------
module cht_mod_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [cht_pkg::KEY_W-1:0]      dividend,
   input  logic [cht_pkg::CFG_W-1:0]      divisor,
   output logic                           done,
   output logic [cht_pkg::CFG_W-1:0]      remainder
);

   logic [cht_pkg::KEY_W-1:0]     dvd_ff;
   logic [cht_pkg::CFG_W-1:0]     div_ff;
   logic [cht_pkg::CFG_W-1:0]     rem_ff;
   logic [cht_pkg::CFG_W-1:0]     rem_in;
   logic [cht_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic                          run_ff;
   logic                          done_ff;

   // Retire the top DIV_STEP dividend bits: shift in, compare, subtract
   always_comb begin
      logic [cht_pkg::REM_W-1:0] part;
      part = {1'b0, rem_ff};
      for (int i = 0; i < cht_pkg::DIV_STEP; i++) begin
         part = {part[cht_pkg::REM_W-2:0], dvd_ff[cht_pkg::KEY_W-1-i]};
         if (part >= {1'b0, div_ff}) begin
            part = part - {1'b0, div_ff};
         end
      end
      rem_in = part[cht_pkg::CFG_W-1:0];
   end

   // Hold operands, advance the digit count, pulse done on the last digit
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            dvd_ff <= dividend;
            div_ff <= divisor;
            rem_ff <= '0;
            cnt_ff <= '0;
            run_ff <= 1'b1;
         end else if (run_ff) begin
            dvd_ff <= dvd_ff << cht_pkg::DIV_STEP;
            rem_ff <= rem_in;
            cnt_ff <= cnt_ff + cht_pkg::DIV_CNT_W'(1);
            if (cnt_ff == cht_pkg::DIV_CNT_W'(cht_pkg::DIV_CYCLES - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for counting_hash_table. A scoreboard keeps its own
// copy of the bucketed key/count store and the slot count, predicts every
// response and compares each strobed response with the oldest prediction.
// Stimulus: directed corner words, then random bursts under several slot
// count settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb;

   localparam int SLOTS        = 64;
   localparam int WAYS         = 4;
   localparam int ENTRIES      = SLOTS * WAYS;
   localparam int RANDOM_WORDS = 1250;
   localparam int PHASES       = 8;
   localparam int POOL_SIZE    = 48;
   localparam int STALL_LIMIT  = 2000;
   localparam int TAIL_CYCLES  = 32;

   typedef struct packed {
      logic [cht_pkg::COUNT_W-1:0] count;
      logic                        found;
      logic                        full;
   } tally_type;

   // Scoreboard: mirror of the store plus the queue of awaited responses
   class occurrence_book;
      logic [cht_pkg::KEY_W-1:0]   entry_key   [ENTRIES];
      logic [cht_pkg::COUNT_W-1:0] entry_count [ENTRIES];
      bit                          entry_used  [ENTRIES];
      logic [cht_pkg::CFG_W-1:0]   divisor;
      tally_type                   awaited_tallies [$];
      int                          errors, checked, hits, drops;

      function new();
         foreach (entry_used[i]) entry_used[i] = 1'b0;
         divisor = 7'd64;
         errors  = 0;
         checked = 0;
         hits    = 0;
         drops   = 0;
      endfunction

      // Clamp the divisor the way the block uses it
      function int unsigned bucket_span();
         if (divisor == 0) return 1;
         if (divisor > SLOTS) return SLOTS;
         return 32'(divisor);
      endfunction

      function int bucket_of_key(logic [cht_pkg::KEY_W-1:0] key);
         logic [cht_pkg::KEY_W-1:0] magnitude;
         magnitude = key[cht_pkg::KEY_W-1] ? -key : key;
         return int'(magnitude % bucket_span());
      endfunction

      // Apply one accepted word to the mirror and queue its response
      function void count_key(logic op, logic [cht_pkg::KEY_W-1:0] key);
         int        base, hit_at, free_at;
         tally_type tally;
         base    = bucket_of_key(key) * WAYS;
         hit_at  = -1;
         free_at = -1;
         for (int w = 0; w < WAYS; w++) begin
            if (entry_used[base + w]) begin
               if (hit_at < 0 && entry_key[base + w] == key) hit_at = base + w;
            end else if (free_at < 0) begin
               free_at = base + w;
            end
         end
         tally = '0;
         if (hit_at >= 0) begin
            tally.found = 1'b1;
            tally.count = entry_count[hit_at];
            if (op == cht_pkg::OP_INSERT && tally.count != cht_pkg::COUNT_MAX) begin
               tally.count         = tally.count + 1'b1;
               entry_count[hit_at] = tally.count;
            end
         end else if (op == cht_pkg::OP_INSERT) begin
            if (free_at >= 0) begin
               entry_used[free_at]  = 1'b1;
               entry_key[free_at]   = key;
               entry_count[free_at] = cht_pkg::COUNT_W'(1);
               tally.count          = cht_pkg::COUNT_W'(1);
            end else begin
               tally.full = 1'b1;
            end
         end
         awaited_tallies.push_back(tally);
      endfunction

      // Compare one strobed response with the oldest prediction
      function void check_tally(tally_type got);
         tally_type want;
         if (awaited_tallies.size() == 0) begin
            errors++;
            $display("%0t: response with none awaited: count %0d found %0d bucket_full %0d",
                     $time, got.count, got.found, got.full);
            return;
         end
         want = awaited_tallies.pop_front();
         checked++;
         if (got.count !== want.count) begin
            errors++;
            $display("%0t: count mismatch, expected %0d, actual %0d",
                     $time, want.count, got.count);
         end
         if (got.found !== want.found) begin
            errors++;
            $display("%0t: found mismatch, expected %0d, actual %0d",
                     $time, want.found, got.found);
         end
         if (got.full !== want.full) begin
            errors++;
            $display("%0t: bucket_full mismatch, expected %0d, actual %0d",
                     $time, want.full, got.full);
         end
         if (want.found) hits++;
         if (want.full) drops++;
      endfunction
   endclass

   logic                             clock;
   logic                             reset;
   logic                             start;
   logic                             busy;
   logic                             req_operation;
   logic signed [cht_pkg::KEY_W-1:0] req_key_value;
   logic                             rsp_valid;
   logic [cht_pkg::COUNT_W-1:0]      rsp_count;
   logic                             rsp_found;
   logic                             rsp_bucket_full;
   logic                             csr_valid;
   logic                             csr_ready;
   logic [cht_pkg::CFG_W-1:0]        csr_slot_count;

   occurrence_book            book;
   logic [cht_pkg::KEY_W-1:0] key_pool [POOL_SIZE];
   int                        words_sent;
   int                        stall_cycles;

   counting_hash_table #(
      .SLOTS (SLOTS),
      .WAYS  (WAYS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_operation   (req_operation),
      .req_key_value   (req_key_value),
      .rsp_valid       (rsp_valid),
      .rsp_count       (rsp_count),
      .rsp_found       (rsp_found),
      .rsp_bucket_full (rsp_bucket_full),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_slot_count  (csr_slot_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Check responses and watch for a stalled run
   always @(posedge clock) begin
      if (reset) begin
         stall_cycles <= 0;
      end else begin
         if (rsp_valid) book.check_tally({rsp_count, rsp_found, rsp_bucket_full});
         if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
            stall_cycles <= 0;
         end else if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("tb NOT OK");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   // Present one word and hold it until the block takes it
   task automatic send_word(input logic op, input logic [cht_pkg::KEY_W-1:0] key);
      start         <= 1'b1;
      req_operation <= op;
      req_key_value <= key;
      @(posedge clock);
      while (busy) @(posedge clock);
      book.count_key(op, key);
      words_sent++;
   endtask

   // Drop start for a gap; a zero gap keeps the next word back to back
   task automatic hold_off(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Stop sending until every awaited response is in and the block is idle
   task automatic drain();
      if (start) start <= 1'b0;
      while (book.awaited_tallies.size() != 0 || busy) @(posedge clock);
   endtask

   task automatic write_divisor(input logic [cht_pkg::CFG_W-1:0] value);
      csr_valid      <= 1'b1;
      csr_slot_count <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      book.divisor = value;
      csr_valid <= 1'b0;
   endtask

   function automatic logic pick_operation();
      return ($urandom_range(0, 9) < 6) ? cht_pkg::OP_INSERT : cht_pkg::OP_SEARCH;
   endfunction

   // Mostly repeat keys and bucket mates so hits and full buckets are common
   function automatic logic [cht_pkg::KEY_W-1:0] pick_key();
      int unsigned               pick;
      logic [cht_pkg::KEY_W-1:0] key;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      end else if (pick < 75) begin
         key = $urandom_range(0, 40) * book.bucket_span() + $urandom_range(0, 3);
         if ($urandom_range(0, 1)) key = -key;
      end else if (pick < 85) begin
         case ($urandom_range(0, 4))
            0: key = '0;
            1: key = '1;
            2: key = 32'h8000_0000;
            3: key = 32'h7FFF_FFFF;
            default: key = 32'h8000_0001;
         endcase
      end else begin
         key = $urandom();
      end
      return key;
   endfunction

   // Random bursts with random gaps, now and then a full drain
   task automatic random_phase(input int words);
      int sent, burst;
      sent = 0;
      while (sent < words) begin
         burst = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 16);
         for (int i = 0; i < burst && sent < words; i++) begin
            send_word(pick_operation(), pick_key());
            sent++;
         end
         if ($urandom_range(0, 39) == 0) drain();
         else hold_off(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20));
      end
   endtask

   initial begin
      logic [cht_pkg::CFG_W-1:0] settings [PHASES];
      book           = new();
      reset          = 1'b1;
      start          = 1'b0;
      req_operation  = cht_pkg::OP_INSERT;
      req_key_value  = '0;
      csr_valid      = 1'b0;
      csr_slot_count = 7'd64;
      words_sent     = 0;
      for (int i = 0; i < POOL_SIZE; i++) begin
         key_pool[i] = (i % 3 == 0) ? $urandom_range(0, 200) : $urandom();
         if (i % 2 == 1) key_pool[i] = -key_pool[i];
      end
      settings = '{7'd2, 7'd127, 7'd37, 7'd0, 7'd64, 7'd1, 7'd0, 7'd0};
      settings[6] = cht_pkg::CFG_W'($urandom_range(3, 63));
      settings[7] = cht_pkg::CFG_W'($urandom_range(3, 63));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Corner words at the reset slot count of 64
      send_word(cht_pkg::OP_SEARCH, 32'd0);
      send_word(cht_pkg::OP_INSERT, 32'd0);
      send_word(cht_pkg::OP_INSERT, 32'd0);
      send_word(cht_pkg::OP_SEARCH, 32'd0);
      send_word(cht_pkg::OP_INSERT, 32'h8000_0000);
      send_word(cht_pkg::OP_INSERT, 32'h7FFF_FFFF);
      send_word(cht_pkg::OP_INSERT, 32'hFFFF_FFFF);
      send_word(cht_pkg::OP_INSERT, 32'd1);
      send_word(cht_pkg::OP_SEARCH, 32'hFFFF_FFFF);
      send_word(cht_pkg::OP_INSERT, 32'd64);
      send_word(cht_pkg::OP_INSERT, -32'sd64);
      // bucket zero is now full: drop a new key, still count a held one
      send_word(cht_pkg::OP_INSERT, 32'd128);
      send_word(cht_pkg::OP_SEARCH, 32'd128);
      send_word(cht_pkg::OP_INSERT, -32'sd64);
      send_word(cht_pkg::OP_SEARCH, 32'h8000_0000);
      send_word(cht_pkg::OP_SEARCH, 32'h7FFF_FFFF);
      send_word(cht_pkg::OP_INSERT, 32'h8000_0001);
      send_word(cht_pkg::OP_SEARCH, 32'h5555_5555);
      send_word(cht_pkg::OP_INSERT, 32'hAAAA_AAAA);
      drain();

      // Change the slot count between phases while entries stay held
      foreach (settings[p]) begin
         drain();
         write_divisor(settings[p]);
         random_phase(RANDOM_WORDS / PHASES);
      end
      drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d words sent, %0d responses checked: %0d hits, %0d dropped inserts",
               words_sent, book.checked, book.hits, book.drops);
      $display("slot counts used: 64 at reset, then 2, 127, 37, 0, 64, 1, %0d, %0d",
               settings[6], settings[7]);
      if (book.errors == 0 && book.awaited_tallies.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
